>>> hw/rtl/mse_pkg.sv
// mse_pkg: sizes and shared types for the merge sort engine
// no dependencies; used by merge_sort_engine, mse_checker, mse_scoreboard and merge_sort_engine_test
package mse_pkg;
	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 32;
	localparam int ADDR_BITS  = $clog2(MAX_ITEMS);
	localparam int CNT_BITS   = ADDR_BITS + 1;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [ADDR_BITS-1:0]         addr_t;
	typedef logic [CNT_BITS-1:0]          count_t;
endpackage

>>> hw/rtl/merge_sort_engine.sv
// merge_sort_engine: stable ascending merge sort over two ping-pong memories
// depends on mse_pkg
// load: one request per cycle, busy stays low while values are stored.
// sort: for n stored values, ceil(log2 n) passes; each merges its pairs of runs at one element
//   per cycle through the single read port of the source memory, after ST_SEG, ST_LDA and
//   ST_LDB prime both run heads of each pair; readout then strobes the n results in order, the
//   first one coming through the ST_OUT state and the registered read of the sorted memory.
// results are strobed for one cycle each; the receiver cannot stall the engine.
// reset clears the count and control state only; memory contents stay undefined.
module merge_sort_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mse_pkg::value_t value,
	input  logic            final_item,
	output logic            out_strobe,
	output mse_pkg::value_t sorted_value,
	output logic            last_out
);
	import mse_pkg::*;

	// one-hot sequencer states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SEG   = 6'b000010,
		ST_LDA   = 6'b000100,
		ST_LDB   = 6'b001000,
		ST_MERGE = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	// two memories; each pass reads one and writes the other, so a read and
	// a write never meet on the same memory and no forwarding is needed
	value_t mem0 [MAX_ITEMS];
	value_t mem1 [MAX_ITEMS];
	value_t rd0_q, rd1_q;

	logic   src_q;                 // memory holding the current runs
	count_t count_q;               // stored items, saturates at MAX_ITEMS
	count_t n_q;                   // size of the set being sorted
	count_t width_q;               // run width of this pass
	count_t lo_q, mid_q, hi_q;     // current pair of runs
	count_t a_q, b_q, k_q;         // left head, right head, write index
	value_t head_a_q, head_b_q;
	logic   ref_a_q, ref_b_q;      // head arrives from memory this cycle
	logic   strb_s1, last_s1;

	logic   accept;
	logic   wr_en, wr_sel;
	addr_t  wr_addr, rd_addr;
	value_t wr_data, rdata;
	value_t ha, hb;
	logic   a_ok, b_ok, take_a;
	logic   [CNT_BITS:0] sum_mid, sum_hi;
	count_t width_nx;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign rdata  = src_q ? rd1_q : rd0_q;

	// effective run heads: freshly read data replaces the stale register
	assign ha     = ref_a_q ? rdata : head_a_q;
	assign hb     = ref_b_q ? rdata : head_b_q;
	assign a_ok   = (a_q < mid_q);
	assign b_ok   = (b_q < hi_q);
	// left run wins on equal values, which keeps the sort stable
	assign take_a = a_ok && (!b_ok || (ha <= hb));

	// bounds of the next pair of runs, clipped to the set size
	assign sum_mid  = {1'b0, lo_q} + {1'b0, width_q};
	assign sum_hi   = {1'b0, lo_q} + {width_q, 1'b0};
	assign width_nx = {width_q[CNT_BITS-2:0], 1'b0};

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_sel  = 1'b0;
		wr_addr = '0;
		wr_data = value;
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				wr_en   = accept && (count_q < count_t'(MAX_ITEMS));
				wr_addr = count_q[ADDR_BITS-1:0];
			end
			ST_SEG:   rd_addr = lo_q[ADDR_BITS-1:0];
			ST_LDA:   rd_addr = b_q[ADDR_BITS-1:0];
			ST_MERGE: begin
				wr_en   = 1'b1;
				wr_sel  = !src_q;
				wr_addr = k_q[ADDR_BITS-1:0];
				wr_data = take_a ? ha : hb;
				rd_addr = take_a ? addr_t'(a_q + 1'b1) : addr_t'(b_q + 1'b1);
			end
			ST_OUT:   rd_addr = k_q[ADDR_BITS-1:0];
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && !wr_sel) begin
			mem0[wr_addr] <= wr_data;
		end
		rd0_q <= mem0[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_sel) begin
			mem1[wr_addr] <= wr_data;
		end
		rd1_q <= mem1[rd_addr];
	end

	// run heads are payload and need no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LDA: head_a_q <= rdata;
			ST_LDB: head_b_q <= rdata;
			ST_MERGE: begin
				head_a_q <= ha;
				head_b_q <= hb;
			end
			default: begin
				head_a_q <= head_a_q;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			src_q   <= 1'b0;
			count_q <= '0;
			n_q     <= '0;
			width_q <= '0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
			ref_a_q <= 1'b0;
			ref_b_q <= 1'b0;
			strb_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			strb_s1 <= 1'b0;
			last_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (count_q < count_t'(MAX_ITEMS)) begin
							count_q <= count_q + 1'b1;
						end
						if (final_item) begin
							// set size includes this request's own value, unless the store is already full
							if (count_q < count_t'(MAX_ITEMS)) begin
								n_q <= count_q + 1'b1;
							end else begin
								n_q <= count_t'(MAX_ITEMS);
							end
							count_q <= '0;
							src_q   <= 1'b0;
							width_q <= count_t'(1);
							lo_q    <= '0;
							k_q     <= '0;
							// a single value needs no merge pass
							state_q <= (count_q == '0) ? ST_OUT : ST_SEG;
						end
					end
				end
				ST_SEG: begin
					// read of the left head is issued this cycle
					mid_q   <= (sum_mid > {1'b0, n_q}) ? n_q : sum_mid[CNT_BITS-1:0];
					hi_q    <= (sum_hi > {1'b0, n_q}) ? n_q : sum_hi[CNT_BITS-1:0];
					b_q     <= (sum_mid > {1'b0, n_q}) ? n_q : sum_mid[CNT_BITS-1:0];
					a_q     <= lo_q;
					k_q     <= lo_q;
					state_q <= ST_LDA;
				end
				ST_LDA: begin
					// left head arrives, right head read issued
					state_q <= ST_LDB;
				end
				ST_LDB: begin
					// right head arrives, both heads now sit in registers
					ref_a_q <= 1'b0;
					ref_b_q <= 1'b0;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					ref_a_q <= take_a;
					ref_b_q <= !take_a;
					if (take_a) begin
						a_q <= a_q + 1'b1;
					end else begin
						b_q <= b_q + 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (k_q + 1'b1 == hi_q) begin
						lo_q <= hi_q;
						state_q <= ST_SEG;
						if (hi_q == n_q) begin
							// pass complete: swap memories and double the run width
							src_q   <= !src_q;
							width_q <= width_nx;
							lo_q    <= '0;
							k_q     <= '0;
							if (width_nx >= n_q || width_q[CNT_BITS-1]) begin
								state_q <= ST_OUT;
							end
						end
					end
				end
				ST_OUT: begin
					strb_s1 <= 1'b1;
					last_s1 <= (k_q + 1'b1 == n_q);
					k_q     <= k_q + 1'b1;
					if (k_q + 1'b1 == n_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result shows the registered read data of the sorted memory
	assign out_strobe   = strb_s1;
	assign last_out     = last_s1;
	assign sorted_value = rdata;

endmodule

>>> hw/rtl/mse_checker.sv
// mse_checker: port-level checks for merge_sort_engine, bound into every merge_sort_engine instance
// depends on mse_pkg and merge_sort_engine
module mse_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input mse_pkg::value_t value,
	input logic            final_item,
	input logic            out_strobe,
	input mse_pkg::value_t sorted_value,
	input logic            last_out
);
	import mse_pkg::*;

	// a final request always starts a sort
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && final_item |=> busy)
		else $error("final request did not start a sort");

	// plain requests are stored without going busy
	a_store_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !final_item |=> !busy)
		else $error("plain request made the engine busy");

	// last marker only with a strobe
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> out_strobe)
		else $error("last marker without a result");

	// nothing follows the last result of a set
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && last_out |=> !out_strobe)
		else $error("result after the last one");

	// results appear only during or just after a sort
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe |-> busy || $past(busy))
		else $error("result while idle");
endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);

>>> tb/sv/mse_checker.sv
// mse_scoreboard: predicts the sorted run that each set causes and checks every strobed result
// depends on mse_pkg; sits beside merge_sort_engine in merge_sort_engine_test
module mse_scoreboard (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  mse_pkg::value_t value,
	input  logic            final_item,
	input  logic            out_strobe,
	input  mse_pkg::value_t sorted_value,
	input  logic            last_out,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mse_pkg::*;

	typedef struct packed {
		value_t v;
		logic   is_last;
	} sorted_elem_t;

	value_t       held [MAX_ITEMS];
	count_t       held_count;
	sorted_elem_t sorted_run_q [$];

	// stable ascending order; equal values are indistinguishable at the outputs
	task automatic predict_sorted_run();
		value_t       run [MAX_ITEMS];
		value_t       key;
		sorted_elem_t el;
		int           n, i, j;
		n = int'(held_count);
		for (i = 0; i < n; i++)
			run[i] = held[i];
		for (i = 1; i < n; i++) begin
			key = run[i];
			j = i - 1;
			while (j >= 0 && run[j] > key) begin
				run[j + 1] = run[j];
				j--;
			end
			run[j + 1] = key;
		end
		for (i = 0; i < n; i++) begin
			el.v       = run[i];
			el.is_last = (i == n - 1);
			sorted_run_q = {sorted_run_q, el};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sorted_elem_t due;
		int           errs;
		errs = 0;
		if (!arst_n) begin
			held_count = '0;
			sorted_run_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (start && !busy) begin
				// a full store ignores the value, the count stays saturated
				if (held_count < MAX_ITEMS) begin
					held[held_count[ADDR_BITS-1:0]] = value;
					held_count = held_count + 1'b1;
				end
				if (final_item) begin
					predict_sorted_run();
					held_count = '0;
				end
			end
			if (out_strobe) begin
				if (sorted_run_q.size() == 0) begin
					$error("unexpected result: sorted_value %0d, last_out %0b",
						sorted_value, last_out);
					errs++;
				end else begin
					due = sorted_run_q.pop_front();
					if (sorted_value !== due.v) begin
						$error("sorted_value: expected %0d, actual %0d",
							$signed(due.v), sorted_value);
						errs++;
					end
					if (last_out !== due.is_last) begin
						$error("last_out: expected %0b, actual %0b", due.is_last, last_out);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending    <= sorted_run_q.size();
		end
	end
endmodule

>>> tb/sv/merge_sort_engine_test.sv
// merge_sort_engine_test: stimulus and verdict for merge_sort_engine
// depends on mse_pkg, merge_sort_engine and mse_scoreboard, which checks every result against its prediction
module merge_sort_engine_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mse_pkg::*;

	// cycles with no request and no result before the run is given up
	localparam int STALL_LIMIT = 5000;
	// quiet cycles after the last result, to catch stray strobes
	localparam int TAIL_CYCLES = 20;

	localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// how the values of one set are spread
	typedef enum int {
		SPREAD_FULL,
		SPREAD_NARROW,
		SPREAD_EXTREME,
		SPREAD_MIXED
	} spread_t;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	value_t value;
	logic   final_item;
	logic   out_strobe;
	value_t sorted_value;
	logic   last_out;

	int     fail_count;
	int     pending;
	int     stall_cycles;
	int     stored_items;
	bit     idling_on;
	value_t batch [$];

	merge_sort_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.final_item   (final_item),
		.out_strobe   (out_strobe),
		.sorted_value (sorted_value),
		.last_out     (last_out)
	);

	mse_scoreboard sort_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.final_item   (final_item),
		.out_strobe   (out_strobe),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: any request or result counts as progress
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((start && !busy) || out_strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic value_t random_value(input spread_t spread);
		case (spread)
			SPREAD_NARROW: begin
				// a handful of values close to zero, so duplicates are common
				random_value = value_t'(int'($urandom_range(0, 6)) - 3);
			end
			SPREAD_EXTREME: begin
				case ($urandom_range(0, 5))
					0: random_value = VALUE_MIN;
					1: random_value = VALUE_MAX;
					2: random_value = '0;
					3: random_value = '1;
					4: random_value = VALUE_MIN + 1;
					default: random_value = VALUE_MAX - 1;
				endcase
			end
			default: begin
				random_value = value_t'($urandom);
			end
		endcase
	endfunction

	// one request: driven at the falling edge, held until taken at a rising edge
	task automatic send_item(input value_t v, input logic is_final);
		@(negedge clk);
		start      = 1'b1;
		value      = v;
		final_item = is_final;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// random burst of idle cycles on the request side
	task automatic sender_gap();
		int n;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 19);
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	// hold requests off until every predicted result has been strobed
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// the batch is one set; its last entry carries final_item
	task automatic send_batch();
		int i;
		for (i = 0; i < batch.size(); i++) begin
			send_item(batch[i], i == batch.size() - 1);
			sender_gap();
		end
		// values beyond capacity are dropped by the engine
		stored_items += (batch.size() > MAX_ITEMS) ? MAX_ITEMS : batch.size();
	endtask

	task automatic fill_batch(input int len, input spread_t spread);
		spread_t s;
		int      i;
		batch.delete();
		for (i = 0; i < len; i++) begin
			s = (spread == SPREAD_MIXED) ? spread_t'($urandom_range(0, 2)) : spread;
			batch = {batch, random_value(s)};
		end
	endtask

	// mostly short sets keep the sort passes brief; now and then a longer one
	task automatic random_set();
		int len;
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
		fill_batch(len, spread_t'($urandom_range(0, 3)));
		send_batch();
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		value      = '0;
		final_item = 1'b0;
		idling_on  = 1'b1;
		stored_items = 0;
		repeat (3)
			@(negedge clk);
		arst_n = 1'b1;

		// directed: a set of one, at the top of the range
		batch = {VALUE_MAX};
		send_batch();
		// both extremes, zero and minus one, with repeats
		batch = {VALUE_MAX, VALUE_MIN, value_t'(0), value_t'(-1), value_t'(1), VALUE_MIN,
			VALUE_MAX, value_t'(0)};
		send_batch();
		// already ascending
		batch = {value_t'(1), value_t'(2), value_t'(3), value_t'(4), value_t'(5)};
		send_batch();
		// strictly descending negatives
		batch = {value_t'(-1), value_t'(-2), value_t'(-3), value_t'(-4), VALUE_MIN};
		send_batch();
		// two equal values
		batch = {value_t'(-7), value_t'(-7)};
		send_batch();

		// random sets, idling switched per set so some sets run back to back
		while (stored_items < 40) begin
			idling_on = ($urandom_range(0, 3) != 0);
			random_set();
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end

		// sender pauses for a full drain, then overfills the store: extra values and
		// the final one arrive with the count saturated, the sort still runs on 64
		wait_drained();
		idling_on = 1'b1;
		fill_batch(MAX_ITEMS + $urandom_range(1, 4), SPREAD_MIXED);
		send_batch();

		while (stored_items < 115) begin
			idling_on = ($urandom_range(0, 3) != 0);
			random_set();
		end

		// closing stretch with no idling at all
		idling_on = 1'b0;
		while (stored_items < 130)
			random_set();

		@(negedge clk);
		start      = 1'b0;
		final_item = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES)
			@(negedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
